[sv/wvws_pkg.sv]
// Package for the weekly valve watering sequencer.
// Holds request/result payload types, configuration and state structs, register indexes.
// No dependencies.
package wvws_pkg;

    localparam int MASK_W    = 49;
    localparam int MINUTES_W = 56;
    localparam int CFG_W     = 56;
    localparam int CFG_IDX_W = 2;
    localparam int SECONDS_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WEEKDAY_MASKS = 2'd0,
        REG_VALVE_MINUTES = 2'd1,
        REG_START_HOUR    = 2'd2,
        REG_START_MINUTE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [4:0] clock_hour;
        logic [5:0] clock_minute;
        logic [2:0] clock_weekday;
    } tick_t;

    typedef struct packed {
        logic [7:0] port_bits;
        logic [2:0] current_valve;
        logic       done_today;
    } result_t;

    typedef struct packed {
        logic [MASK_W-1:0]    weekday_masks;
        logic [MINUTES_W-1:0] valve_minutes;
        logic [4:0]           start_hour;
        logic [5:0]           start_minute;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           valve_index;
        logic [SECONDS_W-1:0] open_seconds;
        logic [2:0]           served_weekday;
        logic [7:0]           port_register;
    } seq_state_t;

endpackage

[sv/weekly_valve_watering_sequencer.sv]
// Top level of the weekly valve watering sequencer.
// Depends on wvws_pkg, wvws_cfg and wvws_step.
//
// Usage:
//   Input channel s_*: one request per second tick, carrying the wall-clock
//   hour, minute and weekday. Result channel m_*: exactly one result per
//   request, in order: the output port image (bit 0 pump, bit k valve k),
//   the valve index and the done-today flag.
//   Configuration: cfg_we/cfg_index/cfg_data write one register per cycle
//   (weekday masks, valve minutes, start hour, start minute); write only
//   while no request is in flight.
// Path: an accepted request sits in the input register, passes the step logic
//   and lands in the result register once that register is free or being
//   drained; m_valid rises as the result lands there.
// Throughput: one request per cycle while m_ready stays high; the step logic
//   between the input register and the result register is the only path.
// Reset (aresetn low, synchronous): valve index 1, all outputs off, no day
//   served, all configuration registers zero, both registers empty.
// Stall: while m_ready is low the result holds; one more request may wait
//   in the input register, after which s_ready drops until m_ready returns.
module weekly_valve_watering_sequencer #(
    parameter int VALVE_COUNT = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wvws_pkg::tick_t                s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wvws_pkg::result_t              m_data,
    input  logic                           cfg_we,
    input  logic [wvws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wvws_pkg::CFG_W-1:0]     cfg_data
);
    import wvws_pkg::*;

    cfg_t       cfg;
    tick_t      tick_reg;
    logic       tick_valid_reg;
    result_t    result_reg;
    logic       result_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    result_next;
    logic       advance;

    wvws_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wvws_step #(
        .VALVE_COUNT (VALVE_COUNT)
    ) u_step (
        .tick       (tick_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Advance the held request into the result register when that slot frees.
    assign advance = tick_valid_reg && (!result_valid_reg || m_ready);
    assign s_ready = !tick_valid_reg || advance;
    assign m_valid = result_valid_reg;
    assign m_data  = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg.valve_index    <= 3'd1;
            state_reg.open_seconds   <= '0;
            state_reg.served_weekday <= 3'd0;
            state_reg.port_register  <= 8'd0;
        end else begin
            // Capture a new request whenever the input register is free or draining.
            if (s_ready) begin
                tick_valid_reg <= s_valid;
            end
            if (advance) begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end else if (m_ready) begin
                // Drop the delivered result.
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            tick_reg <= s_data;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

endmodule

[sv/wvws_cfg.sv]
// Configuration register file of the weekly valve watering sequencer.
// Depends on wvws_pkg for register indexes and the cfg_t struct.
module wvws_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [wvws_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wvws_pkg::CFG_W-1:0]       cfg_data,
    output wvws_pkg::cfg_t                   cfg
);
    import wvws_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_WEEKDAY_MASKS: cfg_reg.weekday_masks <= cfg_data[MASK_W-1:0];
                REG_VALVE_MINUTES: cfg_reg.valve_minutes <= cfg_data[MINUTES_W-1:0];
                REG_START_HOUR:    cfg_reg.start_hour    <= cfg_data[4:0];
                REG_START_MINUTE:  cfg_reg.start_minute  <= cfg_data[5:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/wvws_step.sv]
// Next-state and result logic for one second tick of the watering sequencer.
// Depends on wvws_pkg for tick_t, cfg_t, seq_state_t and result_t.
module wvws_step #(
    parameter int VALVE_COUNT = 7
) (
    input  wvws_pkg::tick_t      tick,
    input  wvws_pkg::cfg_t       cfg,
    input  wvws_pkg::seq_state_t state,
    output wvws_pkg::seq_state_t state_next,
    output wvws_pkg::result_t    result
);
    import wvws_pkg::*;

    localparam logic [3:0] VALVE_LAST = 4'(VALVE_COUNT);

    logic                 time_ok;
    logic                 gate;
    logic [2:0]           k_idx;
    logic [7:0]           day_group;
    logic [7:0]           mins;
    logic [SECONDS_W-1:0] limit;
    logic                 enabled;
    logic [2:0]           day_bit;
    logic [3:0]           k_adv;
    logic [7:0]           valve_bit;

    always_comb begin
        // hour and minute compared as one ordered pair
        if (tick.clock_hour != cfg.start_hour) begin
            time_ok = tick.clock_hour > cfg.start_hour;
        end else begin
            time_ok = tick.clock_minute >= cfg.start_minute;
        end
        gate = (tick.clock_weekday != 3'd0) && (tick.clock_weekday != state.served_weekday)
               && time_ok;

        // out-of-range index falls back to valve 1 (k_idx is k-1)
        if (state.valve_index == 3'd0 || {1'b0, state.valve_index} > VALVE_LAST) begin
            k_idx = 3'd0;
        end else begin
            k_idx = state.valve_index - 3'd1;
        end

        day_group = {1'b0, 7'(cfg.weekday_masks >> (6'(k_idx) * 6'd7))};
        day_bit   = tick.clock_weekday - 3'd1;
        enabled   = day_group[day_bit];
        mins      = 8'(cfg.valve_minutes >> {k_idx, 3'b000});
        limit     = (SECONDS_W'(mins) << 6) - (SECONDS_W'(mins) << 2);
        valve_bit = 8'(9'd2 << k_idx);

        state_next = state;
        k_adv      = {1'b0, k_idx} + 4'd1;
        if (gate) begin
            if (enabled) begin
                state_next.port_register = state.port_register | 8'd1 | valve_bit;
                if (state.open_seconds >= limit) begin
                    state_next.port_register = 8'd0;
                    state_next.open_seconds  = '0;
                    k_adv = k_adv + 4'd1;
                end else begin
                    state_next.open_seconds = state.open_seconds + SECONDS_W'(1);
                end
            end else begin
                k_adv = k_adv + 4'd1;
            end
            if (k_adv > VALVE_LAST) begin
                state_next.served_weekday = tick.clock_weekday;
                k_adv = 4'd1;
            end
            state_next.valve_index = k_adv[2:0];
        end

        result.port_bits     = state_next.port_register;
        result.current_valve = state_next.valve_index;
        result.done_today    = (tick.clock_weekday != 3'd0)
                               && (state_next.served_weekday == tick.clock_weekday);
    end

endmodule
